// ===== hw/rtl/svalloc_pkg.sv =====
// Shared types, codes and pitch table for the voice allocator.
package svalloc_pkg;

    localparam int VOICES_DEF = 6;
    localparam int SOUNDS_DEF = 3;

    localparam int REQ_W   = 2;
    localparam int NOTE_W  = 7;
    localparam int SEL_W   = 8;
    localparam int ACT_W   = 2;
    localparam int VOICE_W = 3;
    localparam int SNDO_W  = 2;
    localparam int PITCH_W = 21;
    localparam int MAP_W   = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_OFF = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_SOUND    = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 2'd0,
        ACT_START    = 2'd1,
        ACT_STOP     = 2'd2,
        ACT_STOP_ALL = 2'd3
    } action_t;

    // notes below PITCH_LO or above PITCH_HI have no frequency
    localparam logic [NOTE_W-1:0] PITCH_LO = 7'd9;
    localparam logic [NOTE_W-1:0] PITCH_HI = 7'd96;
    localparam int PITCH_ENTRIES = 88;

    // equal-tempered pitch, Q13.8 Hz, entry 0 is note 9 (27.5 Hz)
    localparam logic [PITCH_W-1:0] PITCH_TABLE [0:PITCH_ENTRIES-1] = '{
        21'd7040, 21'd7459, 21'd7902,
        21'd8372, 21'd8870, 21'd9397, 21'd9956, 21'd10548, 21'd11175,
        21'd11840, 21'd12544, 21'd13290, 21'd14080, 21'd14917, 21'd15804,
        21'd16744, 21'd17740, 21'd18795, 21'd19912, 21'd21096, 21'd22351,
        21'd23680, 21'd25088, 21'd26580, 21'd28160, 21'd29834, 21'd31609,
        21'd33488, 21'd35479, 21'd37589, 21'd39824, 21'd42192, 21'd44701,
        21'd47359, 21'd50175, 21'd53159, 21'd56320, 21'd59669, 21'd63217,
        21'd66976, 21'd70959, 21'd75178, 21'd79649, 21'd84385, 21'd89402,
        21'd94719, 21'd100351, 21'd106318, 21'd112640, 21'd119338, 21'd126434,
        21'd133952, 21'd141918, 21'd150356, 21'd159297, 21'd168769, 21'd178805,
        21'd189437, 21'd200702, 21'd212636, 21'd225280, 21'd238676, 21'd252868,
        21'd267905, 21'd283835, 21'd300713, 21'd318594, 21'd337539, 21'd357610,
        21'd378874, 21'd401403, 21'd425272, 21'd450560, 21'd477352, 21'd505737,
        21'd535809, 21'd567670, 21'd601425, 21'd637188, 21'd675077, 21'd715219,
        21'd757749, 21'd802807, 21'd850544, 21'd901120, 21'd954703, 21'd1011473,
        21'd1071618
    };

    function automatic logic [PITCH_W-1:0] pitch_lookup(input logic [NOTE_W-1:0] note);
        logic [NOTE_W-1:0] off;
        off = note - PITCH_LO;
        if (note < PITCH_LO || note > PITCH_HI) begin
            pitch_lookup = '0;
        end else begin
            pitch_lookup = PITCH_TABLE[off];
        end
    endfunction

endpackage

// ===== hw/rtl/svalloc_pitch_rom.sv =====
// Registered pitch ROM: note number to Q13.8 Hz frequency.
module svalloc_pitch_rom (
    input  logic                             aclk,
    input  logic [svalloc_pkg::NOTE_W-1:0]   note,
    output logic [svalloc_pkg::PITCH_W-1:0]  pitch_reg
);
    import svalloc_pkg::*;

    always_ff @(posedge aclk) begin
        pitch_reg <= pitch_lookup(note);
    end

endmodule

// ===== hw/rtl/synth_voice_allocator_unit.sv =====
// Polyphonic voice allocator: sequential voice scan, sound select, pitch lookup.
// Note on/off: one voice checked per cycle by a single compare unit in SCAN, then
//   DONE posts the word into the output register once it is empty or being taken.
// Sound select and unknown requests go from IDLE straight to DONE. A new request
//   is taken only in IDLE, so not before the previous word has been posted.
// Reset (aresetn low, synchronous): all voices free, sound 0, no word pending.
module synth_voice_allocator_unit #(
    parameter int VOICES = svalloc_pkg::VOICES_DEF,
    parameter int SOUNDS = svalloc_pkg::SOUNDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [svalloc_pkg::REQ_W-1:0]     s_req_type,
    input  logic [svalloc_pkg::NOTE_W-1:0]    s_note_id,
    input  logic [svalloc_pkg::SEL_W-1:0]     s_sound_sel,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [svalloc_pkg::ACT_W-1:0]     m_action,
    output logic [svalloc_pkg::VOICE_W-1:0]   m_voice,
    output logic [svalloc_pkg::SNDO_W-1:0]    m_sound_now,
    output logic [svalloc_pkg::PITCH_W-1:0]   m_pitch_q8,
    output logic                              m_pitch_valid,
    output logic [svalloc_pkg::MAP_W-1:0]     m_busy_map
);
    import svalloc_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SND_W = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICES - 1);

    // IDLE takes a word, SCAN walks the voices, DONE posts into the output register
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    req_t                   req_reg, req_next;
    logic [NOTE_W-1:0]      note_reg, note_next;
    logic [VOICES-1:0]      busy_reg, busy_next;
    logic [SND_W-1:0]       sound_reg, sound_next;
    action_t                act_reg, act_next;
    logic [IDX_W-1:0]       vsel_reg, vsel_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ACT_W-1:0]       m_action_reg, m_action_next;
    logic [VOICE_W-1:0]     m_voice_reg, m_voice_next;
    logic [SNDO_W-1:0]      m_sound_reg, m_sound_next;
    logic [PITCH_W-1:0]     m_pitch_reg, m_pitch_next;
    logic                   m_pvalid_reg, m_pvalid_next;
    logic [MAP_W-1:0]       m_map_reg, m_map_next;

    // key store, one entry per voice; entries are only compared while busy
    logic [NOTE_W-1:0]      voice_key [VOICES];
    logic                   key_we;
    logic [NOTE_W-1:0]      key_rd;

    logic                   hit;
    logic [PITCH_W-1:0]     rom_pitch;

    // zero-padded views so fixed-width fields work at any parameter value
    logic [VOICES+MAP_W-1:0]  busy_pad;
    logic [IDX_W+VOICE_W-1:0] vsel_pad;
    logic [SND_W+SNDO_W-1:0]  sound_pad;

    svalloc_pitch_rom u_rom (
        .aclk      (aclk),
        .note      (note_reg),
        .pitch_reg (rom_pitch)
    );

    assign key_rd    = voice_key[idx_reg];
    assign busy_pad  = {{MAP_W{1'b0}}, busy_reg};
    assign vsel_pad  = {{VOICE_W{1'b0}}, vsel_reg};
    assign sound_pad = {{SNDO_W{1'b0}}, sound_reg};

    // the shared compare: free voice for note on, matching busy voice for note off
    assign hit = (req_reg == REQ_NOTE_ON) ? !busy_reg[idx_reg]
                                          : (busy_reg[idx_reg] && key_rd == note_reg);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        note_next     = note_reg;
        busy_next     = busy_reg;
        sound_next    = sound_reg;
        act_next      = act_reg;
        vsel_next     = vsel_reg;
        key_we        = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_action_next = m_action_reg;
        m_voice_next  = m_voice_reg;
        m_sound_next  = m_sound_reg;
        m_pitch_next  = m_pitch_reg;
        m_pvalid_next = m_pvalid_reg;
        m_map_next    = m_map_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next  = req_t'(s_req_type);
                    note_next = s_note_id;
                    idx_next  = '0;
                    vsel_next = '0;
                    act_next  = ACT_NONE;
                    case (req_t'(s_req_type))
                        REQ_NOTE_ON, REQ_NOTE_OFF: begin
                            state_next = ST_SCAN;
                        end
                        REQ_SOUND: begin
                            // a new, existing sound stops everything of the old one
                            if (s_sound_sel < SEL_W'(SOUNDS) &&
                                s_sound_sel != SEL_W'(sound_reg)) begin
                                sound_next = SND_W'(s_sound_sel);
                                act_next   = ACT_STOP_ALL;
                            end
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (req_reg == REQ_NOTE_ON) begin
                        busy_next[idx_reg] = 1'b1;
                        key_we             = 1'b1;
                        act_next           = ACT_START;
                    end else begin
                        busy_next[idx_reg] = 1'b0;
                        act_next           = ACT_STOP;
                    end
                    vsel_next  = idx_reg;
                    state_next = ST_DONE;
                end else if (idx_reg == IDX_LAST) begin
                    // no free voice, or key not held: post the word with no action
                    state_next = ST_DONE;
                end else begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_action_next = act_reg;
                    m_voice_next  = vsel_pad[VOICE_W-1:0];
                    m_sound_next  = sound_pad[SNDO_W-1:0];
                    m_map_next    = busy_pad[MAP_W-1:0];
                    // pitch only on note on, even when no voice was free
                    if (req_reg == REQ_NOTE_ON) begin
                        m_pitch_next  = rom_pitch;
                        m_pvalid_next = (rom_pitch != '0);
                    end else begin
                        m_pitch_next  = '0;
                        m_pvalid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            sound_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            sound_reg   <= sound_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        note_reg     <= note_next;
        act_reg      <= act_next;
        vsel_reg     <= vsel_next;
        m_action_reg <= m_action_next;
        m_voice_reg  <= m_voice_next;
        m_sound_reg  <= m_sound_next;
        m_pitch_reg  <= m_pitch_next;
        m_pvalid_reg <= m_pvalid_next;
        m_map_reg    <= m_map_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            voice_key[idx_reg] <= note_reg;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_action      = m_action_reg;
    assign m_voice       = m_voice_reg;
    assign m_sound_now   = m_sound_reg;
    assign m_pitch_q8    = m_pitch_reg;
    assign m_pitch_valid = m_pvalid_reg;
    assign m_busy_map    = m_map_reg;

endmodule

// ===== hw/rtl/svalloc_checker.sv =====
// Port-level checker for the voice allocator, bound to the top level.
module svalloc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [svalloc_pkg::ACT_W-1:0]     m_action,
    input logic [svalloc_pkg::VOICE_W-1:0]   m_voice,
    input logic [svalloc_pkg::PITCH_W-1:0]   m_pitch_q8,
    input logic                              m_pitch_valid,
    input logic [svalloc_pkg::MAP_W-1:0]     m_busy_map
);
    import svalloc_pkg::*;

    // stalled result word holds its action, voice, busy map and pitch
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_voice)
                                && $stable(m_busy_map) && $stable(m_pitch_q8))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // pitch flag agrees with the pitch value
    a_pitch_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_valid == (m_pitch_q8 != '0)))
        else $error("pitch_valid disagrees with pitch");

    // a started voice shows busy, a stopped one free
    a_map_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_voice < 3'd6 && (m_action == ACT_START || m_action == ACT_STOP)
            |-> m_busy_map[m_voice] == (m_action == ACT_START))
        else $error("voice busy bit disagrees with start/stop");

    // sound changes carry no voice and no pitch
    a_stop_all: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ACT_STOP_ALL |-> m_voice == '0 && !m_pitch_valid)
        else $error("stop-all word carries voice or pitch");

endmodule

bind synth_voice_allocator_unit svalloc_checker u_svalloc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_action      (m_action),
    .m_voice       (m_voice),
    .m_pitch_q8    (m_pitch_q8),
    .m_pitch_valid (m_pitch_valid),
    .m_busy_map    (m_busy_map)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the voice allocator: directed table, then random event traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svalloc_pkg::*;

    localparam int VOICES    = VOICES_DEF;
    localparam int SOUNDS    = SOUNDS_DEF;
    localparam int N_RAND    = 1850;      // random words that are not plain no-ops
    localparam int DIR_ROWS  = 25;
    localparam int TAIL      = 16;        // wait after the drain before the final check
    localparam int LIMIT     = 1_000_000; // cycle budget for the whole run
    localparam int MAX_PRINT = 40;

    // Q13.8 Hz per note number, 0 where the note has no frequency
    localparam int unsigned HZ_Q8 [0:107] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 7040, 7459, 7902,
        8372, 8870, 9397, 9956, 10548, 11175,
        11840, 12544, 13290, 14080, 14917, 15804,
        16744, 17740, 18795, 19912, 21096, 22351,
        23680, 25088, 26580, 28160, 29834, 31609,
        33488, 35479, 37589, 39824, 42192, 44701,
        47359, 50175, 53159, 56320, 59669, 63217,
        66976, 70959, 75178, 79649, 84385, 89402,
        94719, 100351, 106318, 112640, 119338, 126434,
        133952, 141918, 150356, 159297, 168769, 178805,
        189437, 200702, 212636, 225280, 238676, 252868,
        267905, 283835, 300713, 318594, 337539, 357610,
        378874, 401403, 425272, 450560, 477352, 505737,
        535809, 567670, 601425, 637188, 675077, 715219,
        757749, 802807, 850544, 901120, 954703, 1011473,
        1071618, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    // one result word as it leaves the block
    typedef struct packed {
        action_t              action;
        logic [VOICE_W-1:0]   voice;
        logic [SNDO_W-1:0]    sound;
        logic [PITCH_W-1:0]   pitch;
        logic                 pitch_ok;
        logic [MAP_W-1:0]     busy;
    } alloc_word_t;

    // directed row: event, plus a hand-typed result where 'typed' is set
    typedef struct packed {
        req_t                 req;
        logic [NOTE_W-1:0]    note;
        logic [SEL_W-1:0]     sel;
        logic                 typed;
        alloc_word_t          want;
    } event_row_t;

    localparam event_row_t EVENT_TAB [0:DIR_ROWS-1] = '{
        // after reset: nothing held, sound 0
        '{REQ_NOTE_OFF, 7'd5,   8'd0,   1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h00}},
        '{REQ_UNUSED,   7'd127, 8'd255, 1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h00}},
        // same sound, then out-of-range selects
        '{REQ_SOUND,    7'd0,   8'd0,   1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h00}},
        '{REQ_SOUND,    7'd0,   8'd255, 1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h00}},
        '{REQ_SOUND,    7'd0,   8'd3,   1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h00}},
        // fill all six voices: table edges and notes with no frequency
        '{REQ_NOTE_ON,  7'd0,   8'd0,   1'b1, '{ACT_START, 3'd0, 2'd0, 21'd0,       1'b0, 6'h01}},
        '{REQ_NOTE_ON,  7'd9,   8'd0,   1'b1, '{ACT_START, 3'd1, 2'd0, 21'd7040,    1'b1, 6'h03}},
        '{REQ_NOTE_ON,  7'd96,  8'd0,   1'b1, '{ACT_START, 3'd2, 2'd0, 21'd1071618, 1'b1, 6'h07}},
        '{REQ_NOTE_ON,  7'd97,  8'd0,   1'b1, '{ACT_START, 3'd3, 2'd0, 21'd0,       1'b0, 6'h0F}},
        '{REQ_NOTE_ON,  7'd127, 8'd0,   1'b1, '{ACT_START, 3'd4, 2'd0, 21'd0,       1'b0, 6'h1F}},
        '{REQ_NOTE_ON,  7'd57,  8'd0,   1'b1, '{ACT_START, 3'd5, 2'd0, 21'd112640,  1'b1, 6'h3F}},
        // all voices busy
        '{REQ_NOTE_ON,  7'd8,   8'd255, 1'b1, '{ACT_NONE,  3'd0, 2'd0, 21'd0,       1'b0, 6'h3F}},
        '{REQ_NOTE_ON,  7'd60,  8'd0,   1'b0, '0},
        // free a middle voice, reuse it with a key already sounding
        '{REQ_NOTE_OFF, 7'd9,   8'd0,   1'b0, '0},
        '{REQ_NOTE_ON,  7'd57,  8'd0,   1'b0, '0},
        // duplicate key: lowest holder first, then the other, then none
        '{REQ_NOTE_OFF, 7'd57,  8'd0,   1'b0, '0},
        '{REQ_NOTE_OFF, 7'd57,  8'd0,   1'b0, '0},
        '{REQ_NOTE_OFF, 7'd57,  8'd0,   1'b0, '0},
        // sound changes keep the held keys
        '{REQ_SOUND,    7'd0,   8'd2,   1'b0, '0},
        '{REQ_SOUND,    7'd0,   8'd2,   1'b0, '0},
        '{REQ_SOUND,    7'd0,   8'd1,   1'b0, '0},
        '{REQ_NOTE_OFF, 7'd0,   8'd0,   1'b0, '0},
        '{REQ_NOTE_OFF, 7'd96,  8'd0,   1'b0, '0},
        '{REQ_NOTE_OFF, 7'd127, 8'd0,   1'b0, '0},
        '{REQ_UNUSED,   7'd0,   8'd0,   1'b0, '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type = '0;
    logic [NOTE_W-1:0]    s_note_id = '0;
    logic [SEL_W-1:0]     s_sound_sel = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ACT_W-1:0]     m_action;
    logic [VOICE_W-1:0]   m_voice;
    logic [SNDO_W-1:0]    m_sound_now;
    logic [PITCH_W-1:0]   m_pitch_q8;
    logic                 m_pitch_valid;
    logic [MAP_W-1:0]     m_busy_map;

    // shadow allocator state
    logic [VOICES-1:0]    held_map = '0;
    logic [NOTE_W-1:0]    held_key [VOICES];
    logic [SNDO_W-1:0]    cur_sound = '0;

    alloc_word_t          pending_words [$];
    int unsigned          mismatches = 0;
    int unsigned          words_seen = 0;
    int unsigned          cycle_cnt = 0;
    bit                   no_idle = 1'b0;   // both sides run flat out while set

    synth_voice_allocator_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_note_id     (s_note_id),
        .s_sound_sel   (s_sound_sel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_voice       (m_voice),
        .m_sound_now   (m_sound_now),
        .m_pitch_q8    (m_pitch_q8),
        .m_pitch_valid (m_pitch_valid),
        .m_busy_map    (m_busy_map)
    );

    always #5 aclk = ~aclk;

    // Advance the shadow state by one event and return the word it yields.
    function automatic alloc_word_t allocate_voice(req_t req, logic [NOTE_W-1:0] note,
                                                   logic [SEL_W-1:0] sel);
        alloc_word_t w;
        bit          hit;
        w   = '0;
        hit = 1'b0;
        case (req)
            REQ_NOTE_ON: begin
                if (note < 7'd108) begin
                    w.pitch = PITCH_W'(HZ_Q8[note]);
                end
                // lowest free voice wins; a full set still reports the pitch
                for (int v = 0; v < VOICES; v++) begin
                    if (!hit && !held_map[v]) begin
                        hit         = 1'b1;
                        held_key[v] = note;
                        held_map[v] = 1'b1;
                        w.action    = ACT_START;
                        w.voice     = VOICE_W'(v);
                    end
                end
            end
            REQ_NOTE_OFF: begin
                // lowest busy voice holding the key is released
                for (int v = 0; v < VOICES; v++) begin
                    if (!hit && held_map[v] && held_key[v] == note) begin
                        hit         = 1'b1;
                        held_map[v] = 1'b0;
                        w.action    = ACT_STOP;
                        w.voice     = VOICE_W'(v);
                    end
                end
            end
            REQ_SOUND: begin
                if (sel < SEL_W'(SOUNDS) && SNDO_W'(sel) != cur_sound) begin
                    cur_sound = SNDO_W'(sel);
                    w.action  = ACT_STOP_ALL;
                end
            end
            default: begin
            end
        endcase
        w.sound    = cur_sound;
        w.pitch_ok = (w.pitch != '0);
        w.busy     = MAP_W'(held_map);
        return w;
    endfunction

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINT) begin
            $display("MISMATCH word %0d: %s got %0d want %0d", words_seen, what, got, want);
        end
    endtask

    // Offer one event word, hold it until taken, then queue what it should yield.
    task automatic send_event(req_t req, logic [NOTE_W-1:0] note, logic [SEL_W-1:0] sel,
                              logic typed, alloc_word_t want);
        alloc_word_t pred;
        int          gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_note_id   <= note;
        s_sound_sel <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge; shadow state moves even for typed rows
        pred = allocate_voice(req, note, sel);
        pending_words.push_back(typed ? want : pred);
    endtask

    // Pull valid down and hold off until every queued result is back.
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    // Random event: mostly note on and note off, offs mostly on held keys, some sound changes, some noise.
    task automatic pick_event(output req_t req, output logic [NOTE_W-1:0] note,
                              output logic [SEL_W-1:0] sel);
        logic [NOTE_W-1:0] held [$];
        int                r;
        r    = $urandom_range(0, 99);
        note = NOTE_W'($urandom);
        sel  = SEL_W'($urandom);
        if (r < 45) begin
            req = REQ_NOTE_ON;
            // a narrow key pool makes duplicates and later matches common
            if ($urandom_range(0, 1) == 0) note = NOTE_W'(55 + $urandom_range(0, 7));
        end else if (r < 85) begin
            req = REQ_NOTE_OFF;
            for (int v = 0; v < VOICES; v++) begin
                if (held_map[v]) held.push_back(held_key[v]);
            end
            if (held.size() != 0 && $urandom_range(0, 4) != 0) begin
                note = held[$urandom_range(0, held.size() - 1)];
            end
        end else if (r < 96) begin
            req = REQ_SOUND;
            if ($urandom_range(0, 3) != 0) sel = SEL_W'($urandom_range(0, SOUNDS));
        end else begin
            req = REQ_UNUSED;
        end
    endtask

    // Stimulus: reset, directed table, random traffic, drain, verdict.
    initial begin
        req_t              req;
        logic [NOTE_W-1:0] note;
        logic [SEL_W-1:0]  sel;
        int                useful;
        int                n;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_event(EVENT_TAB[i].req, EVENT_TAB[i].note, EVENT_TAB[i].sel,
                       EVENT_TAB[i].typed, EVENT_TAB[i].want);
        end
        // sender holds off until the block has posted everything
        wait_results();

        useful = 0;
        n      = 0;
        while (useful < N_RAND) begin
            // a stretch with no idling on either side
            no_idle = (n >= 900 && n < 1100);
            if (n % 400 == 399) wait_results();
            pick_event(req, note, sel);
            send_event(req, note, sel, 1'b0, '0);
            if (req != REQ_UNUSED) useful++;
            n++;
        end
        no_idle = 1'b0;

        wait_results();
        repeat (TAIL) @(posedge aclk);
        if (pending_words.size() != 0) begin
            report_mismatch("words never posted", 0, pending_words.size());
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: check each word taken, stall m_ready at random.
    initial begin
        alloc_word_t want;
        int          stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                words_seen++;
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word, action", m_action, 0);
                end else begin
                    want = pending_words.pop_front();
                    if (m_action !== want.action)
                        report_mismatch("action", m_action, want.action);
                    if (m_voice !== want.voice)
                        report_mismatch("voice", m_voice, want.voice);
                    if (m_sound_now !== want.sound)
                        report_mismatch("sound_now", m_sound_now, want.sound);
                    if (m_pitch_q8 !== want.pitch)
                        report_mismatch("pitch_q8", m_pitch_q8, want.pitch);
                    if (m_pitch_valid !== want.pitch_ok)
                        report_mismatch("pitch_valid", m_pitch_valid, want.pitch_ok);
                    if (m_busy_map !== want.busy)
                        report_mismatch("busy_map", m_busy_map, want.busy);
                end
            end
            // stalls start at any cycle, so they land on every phase of the scan
            if (stall_left == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ===== synth_voice_allocator_unit.f =====
hw/rtl/svalloc_pkg.sv
hw/rtl/svalloc_pitch_rom.sv
hw/rtl/synth_voice_allocator_unit.sv
hw/rtl/svalloc_checker.sv
dv/tb_top.sv
